/* rtl/cds_pkg.sv */
`timescale 1ns / 1ps

package cds_pkg;

  localparam int RATE_W     = 32;
  localparam int STAGES     = RATE_W;  // one quotient bit per divider stage
  localparam int DIV_W      = 10;      // widest divisor the split logic handles
  localparam int PRE_MAX    = 8;
  localparam int POST_MAX   = 64;
  localparam int REG_COUNT  = 8;
  localparam int REG_IDX_W  = 4;
  localparam int PAR_W      = 3;
  localparam int PRE_W      = 3;
  localparam int POST_W     = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  localparam logic [PAR_W-1:0] REMAP_PARENT = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Candidate identity carried alongside the division
  typedef struct packed {
    logic [PAR_W-1:0]  parent;
    logic [PRE_W-1:0]  pre_code;
    logic [POST_W-1:0] post_code;
  } tag_t;

  typedef struct packed {
    logic              ok;
    logic [PRE_W-1:0]  pre_code;
    logic [POST_W-1:0] post_code;
  } split_t;

  typedef struct packed {
    logic [PAR_W-1:0]  parent;
    logic [PRE_W-1:0]  pre_code;
    logic [POST_W-1:0] post_code;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] err;
  } best_t;

  // First pre in 1..8 that divides d with a quotient of at most 64.
  // Quotients by 3, 5, 6 and 7 use reciprocal multiplies that are exact up to 512.
  function automatic split_t split_div(logic [DIV_W-1:0] d);
    split_t             r;
    logic [DIV_W-1:0]   q [PRE_MAX];
    logic [DIV_W+11:0]  m3;
    logic [DIV_W+11:0]  m5;
    logic [DIV_W+11:0]  m7;
    logic [DIV_W+3:0]   back;
    logic               found;
    m3 = (DIV_W+12)'(d) * (DIV_W+12)'(683);
    m5 = (DIV_W+12)'(d) * (DIV_W+12)'(205);
    m7 = (DIV_W+12)'(d) * (DIV_W+12)'(293);
    q[0] = d;
    q[1] = d >> 1;
    q[2] = DIV_W'(m3 >> 11);
    q[3] = d >> 2;
    q[4] = DIV_W'(m5 >> 10);
    q[5] = DIV_W'(m3 >> 12);
    q[6] = DIV_W'(m7 >> 11);
    q[7] = d >> 3;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < PRE_MAX; i++) begin
      back = (DIV_W+4)'(q[i]) * (DIV_W+4)'(i + 1);
      if (!found && back == (DIV_W+4)'(d) && q[i] != '0 &&
          q[i] <= DIV_W'(POST_MAX)) begin
        found       = 1'b1;
        r.ok        = 1'b1;
        r.pre_code  = PRE_W'(i);
        r.post_code = POST_W'(q[i] - DIV_W'(1));
      end
    end
    return r;
  endfunction

endpackage

/* rtl/cds_div_pipe.sv */
`timescale 1ns / 1ps

module cds_div_pipe #(
  parameter int DW = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [cds_pkg::RATE_W-1:0]    dividend_i,
  input  logic [DW-1:0]                 divisor_i,
  input  cds_pkg::tag_t                 tag_i,
  output logic                          out_valid_o,
  output logic [cds_pkg::RATE_W-1:0]    quot_o,
  output cds_pkg::tag_t                 tag_o
);

  localparam int N = cds_pkg::STAGES;
  localparam int W = cds_pkg::RATE_W;

  logic                vld_q [N];
  logic [DW-1:0]       rem_q [N];
  logic [W-1:0]        nq_q  [N];  // dividend bits shift out the top, quotient bits in
  logic [DW-1:0]       dv_q  [N];
  cds_pkg::tag_t       tag_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          src_vld;
    logic [DW-1:0] src_rem;
    logic [W-1:0]  src_nq;
    logic [DW-1:0] src_dv;
    cds_pkg::tag_t src_tag;
    logic [DW:0]   part;
    logic          take;

    if (k == 0) begin : g_first
      assign src_vld = in_valid_i;
      assign src_rem = '0;
      assign src_nq  = dividend_i;
      assign src_dv  = divisor_i;
      assign src_tag = tag_i;
    end else begin : g_next
      assign src_vld = vld_q[k-1];
      assign src_rem = rem_q[k-1];
      assign src_nq  = nq_q[k-1];
      assign src_dv  = dv_q[k-1];
      assign src_tag = tag_q[k-1];
    end

    assign part = {src_rem, src_nq[W-1]};
    assign take = part >= {1'b0, src_dv};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? DW'(part - {1'b0, src_dv}) : part[DW-1:0];
      nq_q[k]  <= {src_nq[W-2:0], take};
      dv_q[k]  <= src_dv;
      tag_q[k] <= src_tag;
    end
  end

  assign out_valid_o = vld_q[N-1];
  assign quot_o      = nq_q[N-1];
  assign tag_o       = tag_q[N-1];

endmodule

/* rtl/cds_best.sv */
`timescale 1ns / 1ps

module cds_best (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cds_pkg::RATE_W-1:0]    rate0_i,
  input  logic [cds_pkg::RATE_W-1:0]    target_i,
  input  logic                          res_valid_i,
  input  logic [cds_pkg::RATE_W-1:0]    res_quot_i,
  input  cds_pkg::tag_t                 res_tag_i,
  output cds_pkg::best_t                best_o,
  output logic                          exact_o
);

  cds_pkg::best_t                best_q, best_d;
  logic                          exact_q, exact_d;
  logic [cds_pkg::RATE_W-1:0]    err;
  logic                          better;

  assign err    = (res_quot_i > target_i) ? res_quot_i - target_i : target_i - res_quot_i;
  assign better = res_valid_i && (err < best_q.err);

  always_comb begin
    best_d  = best_q;
    exact_d = exact_q;
    if (start_i) begin
      // Fallback of input 0 divided by 1 with the worst error; any real hit with a lower error beats it
      best_d.parent    = '0;
      best_d.pre_code  = '0;
      best_d.post_code = '0;
      best_d.rate      = rate0_i;
      best_d.err       = '1;
      exact_d          = 1'b0;
    end else if (better) begin
      best_d.parent    = res_tag_i.parent;
      best_d.pre_code  = res_tag_i.pre_code;
      best_d.post_code = res_tag_i.post_code;
      best_d.rate      = res_quot_i;
      best_d.err       = err;
      exact_d          = (err == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_q <= 1'b0;
    end else begin
      exact_q <= exact_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign best_o  = best_q;
  assign exact_o = exact_q;

endmodule

/* rtl/clock_divider_search.sv */
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tdata[31:0] target frequency
// m_axis    out        tdata[79:0] parent_sel, pre_div_code, post_div_code,
//                                  achieved_hz, error_hz
// cfg       in         cfg_index_i selects parent_rate_0..7, cfg_data_i value
//
// One search steps one parent/divisor pair per cycle and feeds each splittable
// divisor into a 32-stage restoring divider. The result enters the output register
// after the walk over NUM_PARENTS * MAX_DIVISOR pairs and the divider drain, and the
// next input can be taken as it appears; an exact match stops the walk early.
// Input is taken only while idle; the result waits in the output register and a
// new target can be taken while it is stalled. Reset clears the rate registers.

module clock_divider_search #(
  parameter int NUM_PARENTS = 8,
  parameter int MAX_DIVISOR = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [cds_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // target frequency
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // parent_sel[2:0], pre_div_code[5:3], post_div_code[11:6], achieved_hz[43:12],
  // error_hz[75:44], zero[79:76]
  output logic [cds_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [cds_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [cds_pkg::RATE_W-1:0]         cfg_data_i
);

  localparam int DW  = $clog2(MAX_DIVISOR + 1);
  localparam int DRW = $clog2(cds_pkg::STAGES);

  cds_pkg::state_e                 state_q, state_d;
  logic [cds_pkg::PAR_W-1:0]       p_q, p_d;
  logic [DW-1:0]                   d_q, d_d;
  logic [DRW-1:0]                  drain_q, drain_d;
  logic [cds_pkg::RATE_W-1:0]      rate_q [cds_pkg::REG_COUNT];
  logic [cds_pkg::RATE_W-1:0]      target_q;
  logic                            m_valid_q, m_valid_d;
  logic [cds_pkg::OUT_DATA_W-1:0]  m_data_q;

  logic                            in_fire;
  logic                            issue;
  logic                            start;
  logic                            load_out;
  cds_pkg::split_t                 split;
  cds_pkg::tag_t                   issue_tag;
  logic                            div_vld;
  logic [cds_pkg::RATE_W-1:0]      div_quot;
  cds_pkg::tag_t                   div_tag;
  cds_pkg::best_t                  best;
  logic                            exact;
  logic [cds_pkg::PAR_W-1:0]       sel_out;

  assign s_axis_tready_o = (state_q == cds_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign split              = cds_pkg::split_div(cds_pkg::DIV_W'(d_q));
  assign issue_tag.parent    = p_q;
  assign issue_tag.pre_code  = split.pre_code;
  assign issue_tag.post_code = split.post_code;

  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    d_d      = d_q;
    drain_d  = drain_q;
    issue    = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      cds_pkg::ST_IDLE: begin
        if (in_fire) begin
          start   = 1'b1;
          p_d     = '0;
          d_d     = DW'(1);
          state_d = cds_pkg::ST_RUN;
        end
      end
      cds_pkg::ST_RUN: begin
        if (exact) begin
          drain_d = '0;
          state_d = cds_pkg::ST_DRAIN;
        end else begin
          // skip divisors with no pre/post split
          issue = split.ok;
          if (d_q == DW'(MAX_DIVISOR)) begin
            d_d = DW'(1);
            if (p_q == cds_pkg::PAR_W'(NUM_PARENTS - 1)) begin
              drain_d = '0;
              state_d = cds_pkg::ST_DRAIN;
            end else begin
              p_d = p_q + 1'b1;
            end
          end else begin
            d_d = d_q + 1'b1;
          end
        end
      end
      cds_pkg::ST_DRAIN: begin
        // wait for the divider to empty and the last compare to land
        drain_d = drain_q + 1'b1;
        if (drain_q == DRW'(cds_pkg::STAGES - 1)) begin
          state_d = cds_pkg::ST_DONE;
        end
      end
      cds_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = cds_pkg::ST_IDLE;
        end
      end
      default: state_d = cds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cds_pkg::ST_IDLE;
      p_q     <= '0;
      d_q     <= DW'(1);
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      d_q     <= d_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cds_pkg::REG_COUNT; i++) begin
        rate_q[i] <= '0;
      end
    end else if (cfg_we_i && cfg_index_i < cds_pkg::REG_IDX_W'(cds_pkg::REG_COUNT)) begin
      rate_q[cfg_index_i[cds_pkg::PAR_W-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      target_q <= s_axis_tdata_i;
    end
  end

  cds_div_pipe #(
    .DW (DW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (issue),
    .dividend_i  (rate_q[p_q]),
    .divisor_i   (d_q),
    .tag_i       (issue_tag),
    .out_valid_o (div_vld),
    .quot_o      (div_quot),
    .tag_o       (div_tag)
  );

  cds_best u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .rate0_i     (rate_q[0]),
    .target_i    (target_q),
    .res_valid_i (div_vld),
    .res_quot_i  (div_quot),
    .res_tag_i   (div_tag),
    .best_o      (best),
    .exact_o     (exact)
  );

  assign sel_out   = (best.parent == cds_pkg::REMAP_PARENT) ? '0 : best.parent;
  assign m_valid_d = load_out ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {4'b0, best.err, best.rate, best.post_code, best.pre_code, sel_out};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef ASSERT_OFF
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == cds_pkg::ST_RUN)
    else $error("search did not start after input transfer");

  a_divisor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cds_pkg::ST_RUN |-> (d_q != '0 && d_q <= DW'(MAX_DIVISOR)))
    else $error("divisor counter out of range");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cds_pkg::ST_IDLE |-> !div_vld)
    else $error("divider busy while idle");

  a_error_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cds_pkg::ST_IDLE && $past(state_q) != cds_pkg::ST_IDLE)
      |-> best.err <= $past(best.err))
    else $error("best error grew during search");
`endif

endmodule
